// ----- src/apr_pkg.sv -----
// ----------------------------------------------------------------------------
// apr_pkg
// Types, constants and fixed-point helpers for the accumulated pixel resolve.
// ----------------------------------------------------------------------------
package apr_pkg;

    localparam int GAMMA_TABLE_BITS_DEF = 12;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_MODE   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DITHER_ENABLE = 1'd1;

    localparam longint unsigned Q31One = 64'd1 << 31;

    // BT.601 mix, Q0.16, rows Y, Cb, Cr
    localparam logic signed [17:0] MIX_COEF [3][3] = '{
        '{ 18'sd19595,  18'sd38470,  18'sd7471 },
        '{-18'sd11059, -18'sd21709,  18'sd32768},
        '{ 18'sd32768, -18'sd27439, -18'sd5329 }
    };

    typedef struct packed {
        logic [31:0] sum_red;
        logic [31:0] sum_green;
        logic [31:0] sum_blue;
        logic [15:0] sample_count;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
    } pixel_out_t;

    function automatic longint unsigned q31_mul(longint unsigned a, longint unsigned b);
        return (a * b) >> 31;
    endfunction

    function automatic longint unsigned q31_pow12(longint unsigned t);
        longint unsigned t2;
        longint unsigned t4;
        longint unsigned t8;
        t2 = q31_mul(t, t);
        t4 = q31_mul(t2, t2);
        t8 = q31_mul(t4, t4);
        return q31_mul(t8, t4);
    endfunction

endpackage

// ----- src/accumulated_pixel_resolve_8bit.sv -----
// ----------------------------------------------------------------------------
// accumulated_pixel_resolve_8bit
// Divides accumulated color sums by the sample count, applies the sRGB encode
// table, optional BT.601 mix, dither and rounding to three bytes.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; one divider step per stage, one
// gamma ROM per channel. busy is always low and the receiver cannot stall.
// Reset: clears the valid chain and both configuration registers.
module accumulated_pixel_resolve_8bit
    import apr_pkg::*;
#(
    parameter int GAMMA_TABLE_BITS = GAMMA_TABLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  pixel_in_t              pixel_in,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   done,
    output pixel_out_t             result
);

    localparam int G         = GAMMA_TABLE_BITS;
    localparam int TableSize = 1 << G;
    localparam int Lat       = G + 6;
    localparam longint unsigned Nm1 = TableSize - 1;

    localparam logic signed [55:0] Scale   = 56'sd65535 <<< 24;
    localparam logic signed [55:0] MaxX    = 56'sd255 * Scale;
    localparam logic signed [55:0] OffTerm = 56'sd128 * Scale;
    localparam logic signed [55:0] HalfS   = Scale >>> 1;

    typedef logic [15:0] rom_t [TableSize];

    // elaboration-time long division for the table build
    function automatic longint unsigned const_udiv(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic rom_t build_rom();
        rom_t            r;
        longint unsigned e;
        longint unsigned s;
        longint unsigned t;
        longint unsigned c;
        for (longint unsigned i = 0; i <= Nm1; i++)
        begin
            if (i * 10000000 <= 31308 * Nm1)
            begin
                e = const_udiv(65535 * 1292 * i + 50 * Nm1, 100 * Nm1);
            end
            else
            begin
                if (i == Nm1)
                begin
                    s = Q31One;
                end
                else
                begin
                    t = 0;
                    for (int b = 30; b >= 0; b--)
                    begin
                        c = t | (64'd1 << b);
                        if (q31_pow12(c) * Nm1 <= (i << 31))
                            t = c;
                    end
                    s = q31_mul(q31_mul(q31_mul(t, t), q31_mul(t, t)), t);
                end
                if (211 * s <= 11 * Q31One)
                    e = 0;
                else
                    e = const_udiv(65535 * (211 * s - 11 * Q31One) + 100 * Q31One,
                                   200 * Q31One);
            end
            if (e > 65535)
                e = 65535;
            r[i[G-1:0]] = e[15:0];
        end
        return r;
    endfunction

    localparam rom_t GammaRom = build_rom();

    typedef struct packed {
        logic [2:0][15:0]  rem;
        logic [2:0][15:0]  low;
        logic [2:0][G-1:0] quot;
        logic [2:0]        sat;
        logic [15:0]       count;
        logic [2:0][7:0]   hash;
    } div_t;

    logic mode_reg;
    logic dither_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            dither_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OUTPUT_MODE:   mode_reg   <= cfg_data[0];
                CFG_DITHER_ENABLE: dither_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // divider pipeline
    div_t div_reg [G+1];
    div_t div_next [G+1];
    logic vld_reg [G+1];

    logic [2:0][31:0] sums;
    logic [15:0]      count_nz;
    logic [7:0]       hash_base;

    always_comb
    begin
        sums      = {pixel_in.sum_red, pixel_in.sum_green, pixel_in.sum_blue};
        count_nz  = (pixel_in.sample_count == 16'd0) ? 16'd1 : pixel_in.sample_count;
        hash_base = pixel_in.pixel_x[7:0] + 8'(pixel_in.pixel_y[7:0] * 8'd236);
        div_next[0].count = count_nz;
        for (int c = 0; c < 3; c++)
        begin
            div_next[0].rem[2-c]  = sums[2-c][31:16];
            div_next[0].low[2-c]  = sums[2-c][15:0];
            div_next[0].quot[2-c] = '0;
            div_next[0].sat[2-c]  = sums[2-c][31:16] >= count_nz;
            div_next[0].hash[2-c] = dither_reg
                ? 8'((hash_base + 8'(67 * c)) * 8'd119) : 8'd128;
        end
    end

    for (genvar k = 1; k <= G; k++)
    begin : g_div
        logic [2:0][16:0] trial;
        logic [2:0]       ge;
        always_comb
        begin
            div_next[k] = div_reg[k-1];
            for (int c = 0; c < 3; c++)
            begin
                trial[c] = {div_reg[k-1].rem[c], div_reg[k-1].low[c][15]};
                ge[c]    = trial[c] >= {1'b0, div_reg[k-1].count};
                div_next[k].rem[c]  = ge[c]
                    ? 16'(trial[c] - {1'b0, div_reg[k-1].count}) : trial[c][15:0];
                div_next[k].low[c]  = {div_reg[k-1].low[c][14:0], 1'b0};
                div_next[k].quot[c] = {div_reg[k-1].quot[c][G-2:0], ge[c]};
            end
        end
    end

    for (genvar k = 0; k <= G; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= (k == 0) ? (start && !busy) : vld_reg[(k == 0) ? 0 : k-1];
        end
        always_ff @(posedge clk)
        begin
            div_reg[k] <= div_next[k];
        end
    end

    // gamma lookup
    logic [15:0] g_reg [3];
    logic [7:0]  hash_g_reg [3];
    logic        vld_g_reg;

    for (genvar c = 0; c < 3; c++)
    begin : g_rom
        logic [G-1:0] idx;
        assign idx = div_reg[G].sat[c] ? {G{1'b1}} : div_reg[G].quot[c];
        always_ff @(posedge clk)
        begin
            g_reg[2-c]      <= GammaRom[idx];
            hash_g_reg[2-c] <= div_reg[G].hash[c];
        end
    end

    // mix products
    logic signed [34:0] prod_reg [3][3];
    logic [7:0]         hash_m_reg [3];
    logic               mode_m_reg;
    logic               vld_m_reg;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (mode_reg)
                    prod_reg[c][j] <= MIX_COEF[c][j] * $signed({1'b0, g_reg[j]});
                else if (c == j)
                    prod_reg[c][j] <= $signed({3'b000, g_reg[j], 16'd0});
                else
                    prod_reg[c][j] <= '0;
            end
            hash_m_reg[c] <= hash_g_reg[c];
        end
        mode_m_reg <= mode_reg;
    end

    logic signed [36:0] lin_reg [3];
    logic [7:0]         hash_s_reg [3];
    logic               mode_s_reg;
    logic               vld_s_reg;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            lin_reg[c] <= 37'(prod_reg[c][0]) + 37'(prod_reg[c][1]) + 37'(prod_reg[c][2]);
            hash_s_reg[c] <= hash_m_reg[c];
        end
        mode_s_reg <= mode_m_reg;
    end

    // pre-round value, clamp, coarse scale
    logic [23:0]        z_reg [3];
    logic               vld_z_reg;
    logic signed [55:0] x_val [3];
    logic signed [55:0] x_clamp [3];
    logic signed [8:0]  dval [3];
    logic [47:0]        y_val [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            dval[c]  = $signed({1'b0, hash_s_reg[c]}) - 9'sd128;
            x_val[c] = (56'(lin_reg[c]) <<< 16) - (56'(lin_reg[c]) <<< 8)
                     + (56'(dval[c]) <<< 32) - (56'(dval[c]) <<< 16)
                     + ((mode_s_reg && c != 0) ? OffTerm : 56'sd0);
            if (x_val[c] < 0)
                x_clamp[c] = '0;
            else if (x_val[c] > MaxX)
                x_clamp[c] = MaxX;
            else
                x_clamp[c] = x_val[c];
            y_val[c] = 48'(x_clamp[c] + HalfS);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
            z_reg[c] <= y_val[c][47:24];
    end

    // divide by 65535: one correction step
    logic [7:0]  q0 [3];
    logic [16:0] rm [3];
    logic [7:0]  q_val [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            q0[c]    = z_reg[c][23:16];
            rm[c]    = {1'b0, z_reg[c][15:0]} + {9'd0, q0[c]};
            q_val[c] = (rm[c] >= 17'd65535) ? q0[c] + 8'd1 : q0[c];
        end
    end

    pixel_out_t result_reg;
    logic       done_reg;

    always_ff @(posedge clk)
    begin
        result_reg <= '{chan0: q_val[0], chan1: q_val[1], chan2: q_val[2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_g_reg <= 1'b0;
            vld_m_reg <= 1'b0;
            vld_s_reg <= 1'b0;
            vld_z_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            vld_g_reg <= vld_reg[G];
            vld_m_reg <= vld_g_reg;
            vld_s_reg <= vld_m_reg;
            vld_z_reg <= vld_s_reg;
            done_reg  <= vld_z_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##Lat done)
        else $error("transaction lost in pipeline");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, Lat))
        else $error("result without transaction");

    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[G] |=> vld_g_reg)
        else $error("valid dropped after divider");

endmodule
